### src/mmbb_pkg.sv
// ----------------------------------------------------------------------------
// mmbb_pkg: shared types and constants
// Field widths, register index codes, sequencer states and divider status.
// ----------------------------------------------------------------------------
package mmbb_pkg;

  localparam int unsigned PRICE_BITS      = 24;
  localparam int unsigned MMBB_MAX_WINDOW = 1024;
  localparam int unsigned WIN_LEN_BITS    = 11;
  localparam int unsigned RADIUS_BITS     = 24;
  localparam int unsigned INDEX_BITS      = 32;
  localparam int unsigned CFG_IDX_BITS    = 2;
  localparam int unsigned CFG_DATA_BITS   = 24;
  localparam int unsigned IN_DATA_BITS    = 2 * PRICE_BITS;
  localparam int unsigned OUT_DATA_BITS   = INDEX_BITS + 2 * PRICE_BITS;

  localparam logic [PRICE_BITS-1:0] MEAN_MAX = {PRICE_BITS{1'b1}};

  // register index codes
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_RADIUS   = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_SUM,
    ST_EMIT,
    ST_DIV
  } mmbb_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/mmbb_window_ram.sv
// ----------------------------------------------------------------------------
// mmbb_window_ram: midpoint window store
// One write port and one registered read port; contents undefined at reset.
// ----------------------------------------------------------------------------
module mmbb_window_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/mmbb_divider.sv
// ----------------------------------------------------------------------------
// mmbb_divider: iterative restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmbb_divider
  import mmbb_pkg::*;
#(
  parameter int unsigned DW = 35,
  parameter int unsigned VW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output div_stat_t     stat_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [VW:0]   trial;
  logic          fits;

  // shift next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? VW'(trial - {1'b0, dvs_q}) : VW'(trial);
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

### src/moving_mean_band_breakout.sv
// ----------------------------------------------------------------------------
// moving_mean_band_breakout: moving-average band breakout detector
// Midpoints of high/low bars go into a ring window; once the window is full,
// each midpoint at or beyond mean +/- radius raises one event word, then the
// mean is refreshed with one shared iterative divider.
// ----------------------------------------------------------------------------
// steps: a fill item is captured, then written in its fill step; a window item
//   is read, summed and emitted; the window-closing fill item and each window
//   item then divide, or zero the mean when the new sum is not positive
// throughput: one item at a time, set by the bit-serial divider; a held event
//   word stalls the next event item in its emit step
// reset: state, counters, config, mean and output valid reset; payload registers and window memory left uncleared
// ----------------------------------------------------------------------------
module moving_mean_band_breakout
  import mmbb_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MMBB_MAX_WINDOW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input words
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // high_price, low_price
  // event words
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // sample_index, mean_at_event,
                                                   // breakout_value
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  // window size width, pointer width and divider dividend width
  localparam int unsigned WW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned DW = PRICE_BITS + WW;
  localparam int unsigned SB = PRICE_BITS + 2;

  mmbb_state_e state_q, state_d;

  // configuration registers
  logic [WIN_LEN_BITS-1:0] win_len_q, win_len_d;
  logic [RADIUS_BITS-1:0]  radius_q, radius_d;

  // window bookkeeping
  logic [PW-1:0]         ptr_q, ptr_d;
  logic [WW-1:0]         fill_cnt_q, fill_cnt_d;
  logic [DW-1:0]         fill_sum_q, fill_sum_d;
  logic [PRICE_BITS-1:0] mean_q, mean_d;
  logic [INDEX_BITS-1:0] item_cnt_q, item_cnt_d;

  // per-item working registers
  logic [PRICE_BITS-1:0] mid_q, mid_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic                  ev_q, ev_d;
  logic [DW-1:0]         prod_q, prod_d;
  logic [DW:0]           num_q, num_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [INDEX_BITS-1:0] out_idx_q, out_idx_d;
  logic [PRICE_BITS-1:0] out_mean_q, out_mean_d;
  logic [PRICE_BITS-1:0] out_mid_q, out_mid_d;

  // effective window: zero reads as one, large values saturate
  logic [WW-1:0] win;
  always_comb begin
    if (win_len_q == '0) begin
      win = WW'(1);
    end else if (32'(win_len_q) > 32'(MAX_WINDOW)) begin
      win = WW'(MAX_WINDOW);
    end else begin
      win = WW'(win_len_q);
    end
  end

  logic                  in_acc;
  logic                  cfg_acc;
  logic                  fill_phase;
  logic [PW-1:0]         ptr_next;
  logic [DW-1:0]         sum_new;
  logic                  out_free;
  logic                  proceed;
  logic                  num_pos;
  logic                  ram_we;
  logic                  ram_re;
  logic [PRICE_BITS-1:0] ram_rdata;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [DW-1:0]         div_quo;
  logic [PRICE_BITS-1:0] div_mean;

  // band edges, signed with two spare bits so the lower edge cannot wrap
  logic signed [SB-1:0] band_lo, band_hi, mid_s;
  logic                 quiet;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign cfg_acc    = cfg_valid_i && cfg_ready_o;
  assign fill_phase = fill_cnt_q < win;
  assign ptr_next   = (32'(ptr_q) + 32'd1 >= 32'(win)) ? '0 : ptr_q + PW'(1);
  assign sum_new    = fill_sum_q + DW'(mid_q);
  assign out_free   = !out_valid_q || m_axis_tready;
  assign proceed    = !ev_q || out_free;
  assign num_pos    = !num_q[DW] && (num_q != '0);

  assign band_lo = $signed(SB'(mean_q)) - $signed(SB'(radius_q));
  assign band_hi = $signed(SB'(mean_q)) + $signed(SB'(radius_q));
  assign mid_s   = $signed(SB'(mid_q));
  assign quiet   = (band_lo < mid_s) && (mid_s < band_hi);

  // clamp the quotient to the price range
  assign div_mean = (div_quo[DW-1:PRICE_BITS] != '0) ? MEAN_MAX
                                                    : div_quo[PRICE_BITS-1:0];

  // -------------------------------------------------------------------------
  // sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = fill_phase ? ST_FILL : ST_READ;
        end
      end
      ST_FILL: begin
        // the item that completes the window goes on to divide the sum
        state_d = (32'(fill_cnt_q) + 32'd1 >= 32'(win)) ? ST_EMIT : ST_IDLE;
      end
      ST_READ: state_d = ST_SUM;
      ST_SUM:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (proceed) begin
          state_d = num_pos ? ST_DIV : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // sequencer: outputs and datapath
  // -------------------------------------------------------------------------
  always_comb begin
    win_len_d   = win_len_q;
    radius_d    = radius_q;
    ptr_d       = ptr_q;
    fill_cnt_d  = fill_cnt_q;
    fill_sum_d  = fill_sum_q;
    mean_d      = mean_q;
    item_cnt_d  = item_cnt_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    ev_d        = ev_q;
    prod_d      = prod_q;
    num_d       = num_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_idx_d   = out_idx_q;
    out_mean_d  = out_mean_q;
    out_mid_d   = out_mid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mid_d = PRICE_BITS'((
              (PRICE_BITS + 1)'(s_axis_tdata[PRICE_BITS-1:0])
            + (PRICE_BITS + 1)'(s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS])) >> 1);
          idx_d      = item_cnt_q;
          item_cnt_d = item_cnt_q + INDEX_BITS'(1);
        end
      end
      ST_FILL: begin
        fill_sum_d = sum_new;
        fill_cnt_d = fill_cnt_q + WW'(1);
        ram_we     = 1'b1;
        ptr_d      = ptr_next;
        ev_d       = 1'b0;
        num_d      = {1'b0, sum_new};
      end
      ST_READ: begin
        // oldest entry arrives from the memory next cycle
        ram_re = 1'b1;
        ev_d   = !quiet;
        prod_d = DW'(mean_q) * DW'(win);
      end
      ST_SUM: begin
        num_d  = (DW + 1)'(prod_q) - (DW + 1)'(ram_rdata) + (DW + 1)'(mid_q);
        ram_we = 1'b1;
        ptr_d  = ptr_next;
      end
      ST_EMIT: begin
        if (proceed) begin
          if (ev_q) begin
            out_valid_d = 1'b1;
            out_idx_d   = idx_q;
            out_mean_d  = mean_q;
            out_mid_d   = mid_q;
          end
          if (num_pos) begin
            div_start = 1'b1;
          end else begin
            mean_d = '0;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          mean_d = div_mean;
        end
      end
      default: ;
    endcase

    // configuration is written only while idle
    if (cfg_acc) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LENGTH: begin
          win_len_d  = cfg_data_i[WIN_LEN_BITS-1:0];
          ptr_d      = '0;
          fill_cnt_d = '0;
          fill_sum_d = '0;
        end
        CFG_BAND_RADIUS: radius_d = cfg_data_i[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_len_q   <= WIN_LEN_BITS'(1);
      radius_q    <= '0;
      ptr_q       <= '0;
      fill_cnt_q  <= '0;
      fill_sum_q  <= '0;
      mean_q      <= '0;
      item_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_len_q   <= win_len_d;
      radius_q    <= radius_d;
      ptr_q       <= ptr_d;
      fill_cnt_q  <= fill_cnt_d;
      fill_sum_q  <= fill_sum_d;
      mean_q      <= mean_d;
      item_cnt_q  <= item_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mid_q      <= mid_d;
    idx_q      <= idx_d;
    ev_q       <= ev_d;
    prod_q     <= prod_d;
    num_q      <= num_d;
    out_idx_q  <= out_idx_d;
    out_mean_q <= out_mean_d;
    out_mid_q  <= out_mid_d;
  end

  // -------------------------------------------------------------------------
  // window memory and shared divider
  // -------------------------------------------------------------------------
  mmbb_window_ram #(
    .DEPTH (MAX_WINDOW),
    .AW    (PW),
    .DW    (PRICE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (mid_q),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  mmbb_divider #(
    .DW (DW),
    .VW (WW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_q[DW-1:0]),
    .divisor_i  (win),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // ports; a pending register write goes ahead of the next bar
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_mid_q, out_mean_q, out_idx_q};

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  // fill count never runs past the window
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_cnt_q) <= 32'(win))
    else $error("fill count beyond window");

  // ring pointer stays inside the window
  a_ptr_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < 32'(win))
    else $error("window pointer out of range");

  // divider results only land while the sequencer waits for them
  a_div_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider done outside divide state");

  // the divider is quiet whenever the sequencer is idle
  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

  // an accepted word closes the input until its work is through
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted twice in a row");

endmodule
